### rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define APDR_ASSERT_NOW(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("apdr assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define APDR_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("apdr assertion failed");

`endif

### rtl/apdr_pkg.sv
`default_nettype none

package apdr_pkg;

    // Structure of the reverb network.
    localparam int ROWS     = 4;
    localparam int STAGES   = 2;
    localparam int AP_LINES = ROWS * STAGES;
    localparam int ROW_W    = $clog2(ROWS);

    // Field and datapath widths.
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int OFFSET_W = 13;
    localparam int ACC_W    = 24;
    localparam int SUM_W    = ACC_W + 2;
    localparam int PROD_W   = ACC_W + GAIN_W + 1;

    // Default configuration of the block.
    localparam int DEF_SAMPLE_RATE   = 48000;
    localparam int DEF_MAX_OFFSET    = 4096;
    localparam int DEF_DELAY_DEPTH   = 512;
    localparam int DEF_ALLPASS_DEPTH = 8192;

    // Line lengths in units of 10 microseconds.
    localparam int unsigned DL_LEN_1E5 [ROWS] = '{733, 683, 757, 743};
    localparam int unsigned AP_LEN_1E5 [AP_LINES] =
        '{4591, 6337, 4597, 5479, 4651, 3217, 4643, 6521};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL0,
        ST_AMP0,
        ST_ADD,
        ST_AP_RD,
        ST_AP_Y,
        ST_AP_WB,
        ST_DL_RD,
        ST_DL_WR,
        ST_MUL,
        ST_ACC,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             clr_start;
        logic             clr_step;
        logic             load;
        logic             mul_last;
        logic             amp_init;
        logic             add_in;
        logic             ap_y;
        logic             ap_wb;
        logic             dl_wr;
        logic             mul_tap;
        logic             acc;
        logic             out_load;
        logic [ROW_W-1:0] row;
        logic             stage;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } status_t;

    // Line length in samples, held between one and the line depth.
    function automatic int unsigned line_len(input int unsigned per_1e5,
                                             input int unsigned rate,
                                             input int unsigned depth);
        longint unsigned len;
        len = longint'(per_1e5) * longint'(rate) / 100000;
        if (len < 1)
        begin
            len = 1;
        end
        if (len > depth)
        begin
            len = depth;
        end
        return int'(len);
    endfunction

    // Saturate a widened internal value to the accumulator width.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+2:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W+2:ACC_W-1] == '0 || v[ACC_W+2:ACC_W-1] == '1)
        begin
            r = v[ACC_W-1:0];
        end
        else if (v[ACC_W+2])
        begin
            r = {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Saturate a sum-width value to the sample width.
    function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v[SUM_W-1:SAMPLE_W-1] == '0 || v[SUM_W-1:SAMPLE_W-1] == '1)
        begin
            r = v[SAMPLE_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Halve with round half up: (v + 1) >> 1.
    function automatic logic signed [ACC_W-1:0] round_half(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W:0] t;
        t = {v[ACC_W-1], v} + (ACC_W+1)'(1);
        return t[ACC_W:1];
    endfunction

endpackage

`default_nettype wire

### rtl/apdr_ram.sv
`default_nettype none

// Simple dual-port RAM with registered read data.
module apdr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/apdr_ctrl.sv
`default_nettype none

module apdr_ctrl
    import apdr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    sample_valid,
    output logic         sample_stall,
    input  wire logic    cfg_valid,
    output logic         cfg_ready,
    output logic         result_valid,
    input  wire logic    result_stall,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t           state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             stage_reg, stage_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             cfg_write;
    logic             out_free;

    // Handshake decode.
    assign accept    = sample_valid && (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_CLEAR) || ((state_reg == ST_IDLE) && !sample_valid);
    assign cfg_write = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !result_stall;

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

    // Next state and sequencing counters.
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        stage_next = stage_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (!cfg_write && status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL0;
                end
                else if (cfg_write)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_MUL0:  state_next = ST_AMP0;
            ST_AMP0:
            begin
                state_next = ST_ADD;
                row_next   = '0;
                stage_next = 1'b0;
            end
            ST_ADD:   state_next = ST_AP_RD;
            ST_AP_RD: state_next = ST_AP_Y;
            ST_AP_Y:  state_next = ST_AP_WB;
            ST_AP_WB:
            begin
                stage_next = !stage_reg;
                state_next = stage_reg ? ST_DL_RD : ST_AP_RD;
            end
            ST_DL_RD: state_next = ST_DL_WR;
            ST_DL_WR: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:
            begin
                row_next   = row_reg + ROW_W'(1);
                state_next = (row_reg == ROW_W'(ROWS - 1)) ? ST_DONE : ST_ADD;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd           = '0;
        cmd.row       = row_reg;
        cmd.stage     = stage_reg;
        cmd.clr_start = cfg_write;
        case (state_reg)
            ST_CLEAR: cmd.clr_step = !cfg_write;
            ST_IDLE:  cmd.load     = accept;
            ST_MUL0:  cmd.mul_last = 1'b1;
            ST_AMP0:  cmd.amp_init = 1'b1;
            ST_ADD:   cmd.add_in   = 1'b1;
            ST_AP_Y:  cmd.ap_y     = 1'b1;
            ST_AP_WB: cmd.ap_wb    = 1'b1;
            ST_DL_WR: cmd.dl_wr    = 1'b1;
            ST_MUL:   cmd.mul_tap  = 1'b1;
            ST_ACC:   cmd.acc      = 1'b1;
            ST_DONE:  cmd.out_load = out_free;
            default:  cmd.clr_step = 1'b0;
        endcase
    end

    // Result valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            stage_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/apdr_dp.sv
`default_nettype none

module apdr_dp
    import apdr_pkg::*;
#(
    parameter int SAMPLE_RATE   = DEF_SAMPLE_RATE,
    parameter int MAX_OFFSET    = DEF_MAX_OFFSET,
    parameter int DELAY_DEPTH   = DEF_DELAY_DEPTH,
    parameter int ALLPASS_DEPTH = DEF_ALLPASS_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cmd_t                       cmd,
    output status_t                         status,
    input  wire logic        [OFFSET_W-1:0] offset_samples,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    input  wire logic        [GAIN_W-1:0]   feedback_gain,
    output logic signed      [SAMPLE_W-1:0] combined_out,
    output logic signed      [SAMPLE_W-1:0] wet_out
);

    localparam int AP_TOTAL = AP_LINES * ALLPASS_DEPTH;
    localparam int DL_TOTAL = ROWS * DELAY_DEPTH;
    localparam int AP_AW    = $clog2(AP_TOTAL);
    localparam int DL_AW    = $clog2(DL_TOTAL);
    localparam int AP_HW    = $clog2(ALLPASS_DEPTH);
    localparam int DL_HW    = $clog2(DELAY_DEPTH);
    localparam int AP_LW    = $clog2(ALLPASS_DEPTH + 1);
    localparam int DL_LW    = $clog2(DELAY_DEPTH + 1);
    localparam int AP_SW    = $clog2(SAMPLE_RATE + MAX_OFFSET + ALLPASS_DEPTH + 1);
    localparam int AP_IW    = $clog2(AP_LINES);

    // Fixed line lengths; the offset is later added to the allpass lengths only.
    localparam int unsigned AP_BASE [AP_LINES] = '{
        line_len(AP_LEN_1E5[0], SAMPLE_RATE, ALLPASS_DEPTH),
        line_len(AP_LEN_1E5[1], SAMPLE_RATE, ALLPASS_DEPTH),
        line_len(AP_LEN_1E5[2], SAMPLE_RATE, ALLPASS_DEPTH),
        line_len(AP_LEN_1E5[3], SAMPLE_RATE, ALLPASS_DEPTH),
        line_len(AP_LEN_1E5[4], SAMPLE_RATE, ALLPASS_DEPTH),
        line_len(AP_LEN_1E5[5], SAMPLE_RATE, ALLPASS_DEPTH),
        line_len(AP_LEN_1E5[6], SAMPLE_RATE, ALLPASS_DEPTH),
        line_len(AP_LEN_1E5[7], SAMPLE_RATE, ALLPASS_DEPTH)
    };
    localparam int unsigned DL_LEN [ROWS] = '{
        line_len(DL_LEN_1E5[0], SAMPLE_RATE, DELAY_DEPTH),
        line_len(DL_LEN_1E5[1], SAMPLE_RATE, DELAY_DEPTH),
        line_len(DL_LEN_1E5[2], SAMPLE_RATE, DELAY_DEPTH),
        line_len(DL_LEN_1E5[3], SAMPLE_RATE, DELAY_DEPTH)
    };

    logic signed [SAMPLE_W-1:0] x_reg;
    logic        [GAIN_W-1:0]   g_reg;
    logic signed [ACC_W-1:0]    amp_reg;
    logic signed [ACC_W-1:0]    y_reg;
    logic signed [ACC_W-1:0]    tap_reg;
    logic signed [ACC_W-1:0]    last_tap_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic        [OFFSET_W-1:0] extra_reg;
    logic        [AP_HW-1:0]    ap_head_reg [AP_LINES];
    logic        [DL_HW-1:0]    dl_head_reg [ROWS];
    logic        [AP_AW-1:0]    clr_cnt_reg;
    logic        [AP_AW-1:0]    ap_waddr_reg;
    logic signed [SAMPLE_W-1:0] combined_reg;
    logic signed [SAMPLE_W-1:0] wet_reg;

    logic        [AP_IW-1:0]    ap_idx;
    logic        [AP_SW-1:0]    ap_sum;
    logic        [AP_LW-1:0]    ap_len;
    logic        [AP_HW-1:0]    ap_head;
    logic        [AP_LW-1:0]    ap_head_inc;
    logic        [AP_HW-1:0]    ap_head_adv;
    logic        [AP_AW-1:0]    ap_raddr;
    logic        [DL_LW-1:0]    dl_len;
    logic        [DL_HW-1:0]    dl_head;
    logic        [DL_LW-1:0]    dl_head_inc;
    logic        [DL_HW-1:0]    dl_head_adv;
    logic        [DL_AW-1:0]    dl_addr;

    logic                       ap_we;
    logic        [AP_AW-1:0]    ap_waddr;
    logic signed [ACC_W-1:0]    ap_wdata;
    logic        [ACC_W-1:0]    ap_rdata;
    logic                       dl_we;
    logic        [DL_AW-1:0]    dl_waddr;
    logic signed [ACC_W-1:0]    dl_wdata;
    logic        [ACC_W-1:0]    dl_rdata;

    logic signed [ACC_W-1:0]    mul_a;
    logic signed [GAIN_W:0]     mul_b;
    logic signed [PROD_W:0]     prod_rnd;
    logic signed [ACC_W-1:0]    gain_val;
    logic signed [ACC_W-1:0]    amp_add;
    logic signed [ACC_W-1:0]    ap_y;
    logic signed [ACC_W-1:0]    ap_w;
    logic signed [SUM_W:0]      sum_rnd;
    logic signed [ACC_W:0]      wet_full;

    // Allpass line addressing for the current stage.
    assign ap_idx      = {cmd.row, cmd.stage};
    assign ap_sum      = AP_SW'(AP_BASE[ap_idx]) + AP_SW'(extra_reg);
    assign ap_len      = (ap_sum > AP_SW'(ALLPASS_DEPTH)) ? AP_LW'(ALLPASS_DEPTH)
                                                          : ap_sum[AP_LW-1:0];
    assign ap_head     = (AP_LW'(ap_head_reg[ap_idx]) >= ap_len) ? '0 : ap_head_reg[ap_idx];
    assign ap_head_inc = AP_LW'(ap_head) + AP_LW'(1);
    assign ap_head_adv = (ap_head_inc == ap_len) ? '0 : ap_head_inc[AP_HW-1:0];
    assign ap_raddr    = AP_AW'(ap_idx) * AP_AW'(ALLPASS_DEPTH) + AP_AW'(ap_head);

    // Delay line addressing for the current row.
    assign dl_len      = DL_LW'(DL_LEN[cmd.row]);
    assign dl_head     = (DL_LW'(dl_head_reg[cmd.row]) >= dl_len) ? '0 : dl_head_reg[cmd.row];
    assign dl_head_inc = DL_LW'(dl_head) + DL_LW'(1);
    assign dl_head_adv = (dl_head_inc == dl_len) ? '0 : dl_head_inc[DL_HW-1:0];
    assign dl_addr     = DL_AW'(cmd.row) * DL_AW'(DELAY_DEPTH) + DL_AW'(dl_head);

    // Gain multiply operands and rounding of the registered product.
    assign mul_a    = cmd.mul_last ? last_tap_reg : tap_reg;
    assign mul_b    = $signed({1'b0, g_reg});
    assign prod_rnd = {prod_reg[PROD_W-1], prod_reg} + (PROD_W+1)'(16384);
    assign gain_val = sat_acc(prod_rnd[PROD_W:15]);

    // Dry sample added to the running value.
    assign amp_add = sat_acc((ACC_W+3)'(amp_reg) + (ACC_W+3)'(x_reg));

    // Allpass stage arithmetic, output first and line write next.
    assign ap_y = sat_acc((ACC_W+3)'(round_half(amp_reg)) + (ACC_W+3)'($signed(ap_rdata)));
    assign ap_w = sat_acc((ACC_W+3)'(amp_reg) - (ACC_W+3)'(round_half(y_reg)));

    // Output scaling: sum / 4 with round half up.
    assign sum_rnd  = {sum_reg[SUM_W-1], sum_reg} + (SUM_W+1)'(2);
    assign wet_full = sum_rnd[SUM_W:2];

    // Memory port muxing between the clearing pass and normal work.
    assign ap_we    = cmd.clr_step || cmd.ap_wb;
    assign ap_waddr = cmd.clr_step ? clr_cnt_reg : ap_waddr_reg;
    assign ap_wdata = cmd.clr_step ? '0 : ap_w;
    assign dl_we    = (cmd.clr_step && (clr_cnt_reg < AP_AW'(DL_TOTAL))) || cmd.dl_wr;
    assign dl_waddr = cmd.clr_step ? clr_cnt_reg[DL_AW-1:0] : dl_addr;
    assign dl_wdata = cmd.clr_step ? '0 : amp_reg;

    assign status.clr_last = (clr_cnt_reg == AP_AW'(AP_TOTAL - 1));

    apdr_ram #(
        .WIDTH(ACC_W),
        .DEPTH(AP_TOTAL)
    ) u_ap_ram (
        .clk  (clk),
        .we   (ap_we),
        .waddr(ap_waddr),
        .wdata(ap_wdata),
        .raddr(ap_raddr),
        .rdata(ap_rdata)
    );

    apdr_ram #(
        .WIDTH(ACC_W),
        .DEPTH(DL_TOTAL)
    ) u_dl_ram (
        .clk  (clk),
        .we   (dl_we),
        .waddr(dl_waddr),
        .wdata(dl_wdata),
        .raddr(dl_addr),
        .rdata(dl_rdata)
    );

    // Line state: heads, last tap, offset and the clearing counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            extra_reg    <= '0;
            last_tap_reg <= '0;
            for (int i = 0; i < AP_LINES; i++)
            begin
                ap_head_reg[i] <= '0;
            end
            for (int i = 0; i < ROWS; i++)
            begin
                dl_head_reg[i] <= '0;
            end
        end
        else if (cmd.clr_start)
        begin
            clr_cnt_reg  <= '0;
            extra_reg    <= (offset_samples > OFFSET_W'(MAX_OFFSET)) ? OFFSET_W'(MAX_OFFSET)
                                                                     : offset_samples;
            last_tap_reg <= '0;
            for (int i = 0; i < AP_LINES; i++)
            begin
                ap_head_reg[i] <= '0;
            end
            for (int i = 0; i < ROWS; i++)
            begin
                dl_head_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clr_step && !status.clr_last)
            begin
                clr_cnt_reg <= clr_cnt_reg + AP_AW'(1);
            end
            if (cmd.ap_y)
            begin
                ap_head_reg[ap_idx] <= ap_head_adv;
            end
            if (cmd.dl_wr)
            begin
                dl_head_reg[cmd.row] <= dl_head_adv;
                if (cmd.row == ROW_W'(ROWS - 1))
                begin
                    last_tap_reg <= $signed(dl_rdata);
                end
            end
        end
    end

    // Working registers of one transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= sample_in;
            g_reg <= feedback_gain;
        end
        if (cmd.mul_last || cmd.mul_tap)
        begin
            prod_reg <= PROD_W'(mul_a * mul_b);
        end
        if (cmd.amp_init)
        begin
            amp_reg <= gain_val;
            sum_reg <= '0;
        end
        if (cmd.acc)
        begin
            amp_reg <= gain_val;
            sum_reg <= sum_reg + SUM_W'(gain_val);
        end
        if (cmd.add_in)
        begin
            amp_reg <= amp_add;
        end
        if (cmd.ap_y)
        begin
            y_reg        <= ap_y;
            ap_waddr_reg <= ap_raddr;
        end
        if (cmd.ap_wb)
        begin
            amp_reg <= y_reg;
        end
        if (cmd.dl_wr)
        begin
            tap_reg <= $signed(dl_rdata);
        end
        if (cmd.out_load)
        begin
            combined_reg <= sat_out(SUM_W'(x_reg) + SUM_W'(wet_full));
            wet_reg      <= sat_out(SUM_W'(wet_full));
        end
    end

    assign combined_out = combined_reg;
    assign wet_out      = wet_reg;

endmodule

`default_nettype wire

### rtl/allpass_delay_reverb.sv
// Schroeder-style reverb: four rows of two allpass lines (gain one half) and one
// delay line, fed back through feedback_gain, on Q1.15 samples with 24-bit
// internal values. One transaction is processed at a time, from acceptance to the
// result register: first the feedback multiply, then each row in turn, with one
// read and one write of the line RAMs per line plus a registered gain multiply,
// then the load of the result. The result register frees the input side, so the
// next sample is taken while a result still waits; only when the next result is
// ready and the old one is still stalled does the block hold in its last step.
// After reset and after every write of offset_samples the block clears its line
// RAMs, one entry per cycle unless a further write restarts the pass, through
// 8 * ALLPASS_DEPTH addresses (65536 at the defaults); no sample is accepted
// during that pass, while further register writes are.
`default_nettype none

module allpass_delay_reverb
    import apdr_pkg::*;
#(
    parameter int SAMPLE_RATE   = DEF_SAMPLE_RATE,
    parameter int MAX_OFFSET    = DEF_MAX_OFFSET,
    parameter int DELAY_DEPTH   = DEF_DELAY_DEPTH,
    parameter int ALLPASS_DEPTH = DEF_ALLPASS_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       sample_valid,
    output logic                            sample_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample_in,
    input  wire logic        [GAIN_W-1:0]   feedback_gain,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic signed      [SAMPLE_W-1:0] combined_out,
    output logic signed      [SAMPLE_W-1:0] wet_out,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic        [OFFSET_W-1:0] offset_samples
);

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    apdr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .status      (status),
        .cmd         (cmd)
    );

    // Arithmetic, line memories and result register.
    apdr_dp #(
        .SAMPLE_RATE  (SAMPLE_RATE),
        .MAX_OFFSET   (MAX_OFFSET),
        .DELAY_DEPTH  (DELAY_DEPTH),
        .ALLPASS_DEPTH(ALLPASS_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .offset_samples(offset_samples),
        .sample_in     (sample_in),
        .feedback_gain (feedback_gain),
        .combined_out  (combined_out),
        .wet_out       (wet_out)
    );

endmodule

`default_nettype wire

### rtl/apdr_checker.sv
`default_nettype none

`include "assert_macros.svh"

module apdr_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic sample_valid,
    input wire logic sample_stall,
    input wire logic result_valid,
    input wire logic result_stall,
    input wire logic cfg_valid,
    input wire logic cfg_ready
);

    // A stalled result stays offered.
    `APDR_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid)

    // One transaction at a time: the input stalls right after an acceptance.
    `APDR_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall)

    // A register write starts the clearing pass, which holds off samples.
    `APDR_ASSERT_NEXT(a_clear_after_write, cfg_valid && cfg_ready, sample_stall)

    // A register write and a sample acceptance never share an edge.
    `APDR_ASSERT_NOW(a_write_excl, cfg_valid && cfg_ready, !(sample_valid && !sample_stall))

endmodule

bind allpass_delay_reverb apdr_checker u_apdr_checker (.*);

`default_nettype wire
